FILE: hdl/pcsp_pkg.sv
package pcsp_pkg;

  localparam int IDAT_COUNT_BITS_DEF = 16;
  localparam int OPQ_DEPTH_DEF       = 4;
  localparam int IDAT_OUT_BITS       = 16;
  localparam int IHDR_BYTES          = 13;

  localparam logic [31:0] T_IHDR = 32'h4948_4452;
  localparam logic [31:0] T_PLTE = 32'h504C_5445;
  localparam logic [31:0] T_IDAT = 32'h4944_4154;
  localparam logic [31:0] T_IEND = 32'h4945_4E44;

  localparam logic [7:0] SIG_BYTES [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                          8'h0D, 8'h0A, 8'h1A, 8'h0A};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } item_t;

  typedef struct packed {
    logic [31:0] chunk_type;
    logic [30:0] chunk_length;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  sample_depth;
    logic [7:0]  color_kind;
    logic [7:0]  compression_kind;
    logic [7:0]  filter_kind;
    logic [7:0]  interlace_kind;
    logic [29:0] palette_entries;
    logic [15:0] idat_count;
    logic [2:0]  status;
  } result_t;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_LEN,
    PH_TYPE,
    PH_DATA,
    PH_CRC
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_END        = 3'd1,
    ST_BAD_SIG    = 3'd2,
    ST_SHORT_IHDR = 3'd3,
    ST_BAD_PLTE   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAP_WIDTH,
    OP_CAP_HEIGHT,
    OP_CAP_HDR,
    OP_END,
    OP_BAD_SIG
  } op_kind_t;

  // One command from the byte classifier to the field unit.
  typedef struct packed {
    logic        restart;
    op_kind_t    kind;
    logic [7:0]  data;
    logic [31:0] ctype;
    logic [30:0] clen;
    logic [29:0] pal_q;
    status_t     status;
    logic        pal_load;
    logic        idat_inc;
  } op_t;

  // One base-256 digit of a long division by three: returns {quotient, remainder}.
  function automatic logic [9:0] div3_step(input logic [1:0] rem_in, input logic [7:0] b);
    logic [9:0]  x;
    logic [19:0] prod;
    logic [7:0]  q;
    logic [9:0]  diff;
    x    = {rem_in, b};
    prod = 20'(x) * 20'd683;
    q    = prod[18:11];
    diff = x - (10'(q) * 10'd3);
    return {q, diff[1:0]};
  endfunction

endpackage

FILE: hdl/pcsp_front.sv
module pcsp_front import pcsp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  item_t item,
  output logic  op_push,
  output op_t   op
);

  phase_t      phase, phase_next;
  logic [30:0] idx, idx_next;
  logic [30:0] length, length_next;
  logic [31:0] ctype, ctype_next;
  logic        done, done_next;
  logic [29:0] pal_q, pal_q_next;
  logic [1:0]  pal_rem, pal_rem_next;

  phase_t      eff_phase;
  logic [30:0] eff_idx;
  logic        eff_done;
  logic [7:0]  b;
  logic [9:0]  dstep;
  logic        sig_match;
  logic        ihdr_cap;
  status_t     fin_status;
  logic        fin_pal_load;
  logic        fin_idat_inc;

  assign b         = item.data_byte;
  assign eff_phase = item.start_of_file ? PH_SIG : phase;
  assign eff_idx   = item.start_of_file ? '0 : idx;
  assign eff_done  = item.start_of_file ? 1'b0 : done;
  assign sig_match = (b == SIG_BYTES[eff_idx[2:0]]);
  assign ihdr_cap  = (ctype == T_IHDR) && (length >= 31'(IHDR_BYTES));
  // The top bit of the first length byte is dropped before dividing.
  assign dstep     = (eff_idx == '0) ? div3_step(2'd0, {1'b0, b[6:0]})
                                     : div3_step(pal_rem, b);

  always_comb begin
    fin_status   = ST_OK;
    fin_pal_load = 1'b0;
    fin_idat_inc = 1'b0;
    if (ctype == T_IHDR) begin
      if (length < 31'(IHDR_BYTES)) fin_status = ST_SHORT_IHDR;
    end else if (ctype == T_PLTE) begin
      if (pal_rem != 2'd0) fin_status = ST_BAD_PLTE;
      else fin_pal_load = 1'b1;
    end else if (ctype == T_IDAT) begin
      fin_idat_inc = 1'b1;
    end else if (ctype == T_IEND) begin
      fin_status = ST_END;
    end
  end

  // Next state
  always_comb begin
    phase_next   = phase;
    idx_next     = idx;
    length_next  = length;
    ctype_next   = ctype;
    done_next    = done;
    pal_q_next   = pal_q;
    pal_rem_next = pal_rem;
    if (accept) begin
      phase_next = eff_phase;
      idx_next   = eff_idx;
      done_next  = eff_done;
      if (!eff_done) begin
        case (eff_phase)
          PH_SIG: begin
            if (!sig_match) begin
              done_next = 1'b1;
            end else if (eff_idx[2:0] == 3'd7) begin
              phase_next = PH_LEN;
              idx_next   = '0;
            end else begin
              idx_next = eff_idx + 31'd1;
            end
          end
          PH_LEN: begin
            length_next  = {length[22:0], b};
            pal_q_next   = {pal_q[21:0], dstep[9:2]};
            pal_rem_next = dstep[1:0];
            if (eff_idx == 31'd3) begin
              phase_next = PH_TYPE;
              idx_next   = '0;
            end else begin
              idx_next = eff_idx + 31'd1;
            end
          end
          PH_TYPE: begin
            ctype_next = {ctype[23:0], b};
            if (eff_idx == 31'd3) begin
              phase_next = (length != '0) ? PH_DATA : PH_CRC;
              idx_next   = '0;
            end else begin
              idx_next = eff_idx + 31'd1;
            end
          end
          PH_DATA: begin
            if (eff_idx + 31'd1 == length) begin
              phase_next = PH_CRC;
              idx_next   = '0;
            end else begin
              idx_next = eff_idx + 31'd1;
            end
          end
          PH_CRC: begin
            if (eff_idx == 31'd3) begin
              phase_next = PH_LEN;
              idx_next   = '0;
              done_next  = (fin_status != ST_OK);
            end else begin
              idx_next = eff_idx + 31'd1;
            end
          end
          default: begin
            phase_next = PH_SIG;
            idx_next   = '0;
          end
        endcase
      end
    end
  end

  // Outputs
  always_comb begin
    op          = '0;
    op.kind     = OP_NONE;
    op.status   = ST_OK;
    op.restart  = item.start_of_file;
    op.data     = b;
    op.ctype    = ctype;
    op.clen     = length;
    op.pal_q    = pal_q;
    if (!eff_done) begin
      case (eff_phase)
        PH_SIG: begin
          if (!sig_match) begin
            op.kind   = OP_BAD_SIG;
            op.ctype  = '0;
            op.clen   = '0;
            op.status = ST_BAD_SIG;
          end
        end
        PH_DATA: begin
          if (ihdr_cap) begin
            if (eff_idx < 31'd4) op.kind = OP_CAP_WIDTH;
            else if (eff_idx < 31'd8) op.kind = OP_CAP_HEIGHT;
            else if (eff_idx < 31'(IHDR_BYTES)) op.kind = OP_CAP_HDR;
          end
        end
        PH_CRC: begin
          if (eff_idx == 31'd3) begin
            op.kind     = OP_END;
            op.status   = fin_status;
            op.pal_load = fin_pal_load;
            op.idat_inc = fin_idat_inc;
          end
        end
        default: op.kind = OP_NONE;
      endcase
    end
    op_push = accept && (op.restart || (op.kind != OP_NONE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_SIG;
      idx     <= '0;
      length  <= '0;
      ctype   <= '0;
      done    <= 1'b0;
      pal_q   <= '0;
      pal_rem <= '0;
    end else begin
      phase   <= phase_next;
      idx     <= idx_next;
      length  <= length_next;
      ctype   <= ctype_next;
      done    <= done_next;
      pal_q   <= pal_q_next;
      pal_rem <= pal_rem_next;
    end
  end

endmodule

FILE: hdl/pcsp_opq.sv
module pcsp_opq import pcsp_pkg::*; #(
  parameter int DEPTH = OPQ_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  wdata,
  output logic full,
  input  logic pop,
  output op_t  rdata,
  output logic empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  op_t           mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule

FILE: hdl/pcsp_back.sv
module pcsp_back import pcsp_pkg::*; #(
  parameter int IDAT_COUNT_BITS = IDAT_COUNT_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    op_valid,
  input  op_t     op,
  output logic    op_pop,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  logic [31:0]                width, width_next;
  logic [31:0]                height, height_next;
  logic [39:0]                hdr, hdr_next;
  logic [29:0]                pal, pal_next;
  logic [IDAT_COUNT_BITS-1:0] idat, idat_next;
  logic                       out_valid, out_valid_next;
  result_t                    result_next;

  logic [31:0]                width_base, height_base;
  logic [39:0]                hdr_base;
  logic [29:0]                pal_base;
  logic [IDAT_COUNT_BITS-1:0] idat_base;
  logic                       need_slot;
  logic                       slot_free;

  assign need_slot = (op.kind == OP_END) || (op.kind == OP_BAD_SIG);
  assign slot_free = !out_valid || pop;
  assign op_pop    = op_valid && (!need_slot || slot_free);
  assign empty     = !out_valid;

  assign width_base  = op.restart ? '0 : width;
  assign height_base = op.restart ? '0 : height;
  assign hdr_base    = op.restart ? '0 : hdr;
  assign pal_base    = op.restart ? '0 : pal;
  assign idat_base   = op.restart ? '0 : idat;

  always_comb begin
    width_next  = width;
    height_next = height;
    hdr_next    = hdr;
    pal_next    = pal;
    idat_next   = idat;
    if (op_pop) begin
      width_next  = width_base;
      height_next = height_base;
      hdr_next    = hdr_base;
      pal_next    = pal_base;
      idat_next   = idat_base;
      case (op.kind)
        OP_CAP_WIDTH:  width_next  = {width_base[23:0], op.data};
        OP_CAP_HEIGHT: height_next = {height_base[23:0], op.data};
        OP_CAP_HDR:    hdr_next    = {hdr_base[31:0], op.data};
        OP_END: begin
          if (op.pal_load) pal_next = op.pal_q;
          // saturate at all ones
          if (op.idat_inc && !(&idat_base)) idat_next = idat_base + IDAT_COUNT_BITS'(1);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result_next.chunk_type       = op.ctype;
    result_next.chunk_length     = op.clen;
    result_next.image_width      = width_next;
    result_next.image_height     = height_next;
    result_next.sample_depth     = hdr_next[39:32];
    result_next.color_kind       = hdr_next[31:24];
    result_next.compression_kind = hdr_next[23:16];
    result_next.filter_kind      = hdr_next[15:8];
    result_next.interlace_kind   = hdr_next[7:0];
    result_next.palette_entries  = pal_next;
    result_next.idat_count       = IDAT_OUT_BITS'(idat_next);
    result_next.status           = op.status;
    out_valid_next = out_valid;
    if (op_pop && need_slot) out_valid_next = 1'b1;
    else if (pop) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (op_pop && need_slot) result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width     <= '0;
      height    <= '0;
      hdr       <= '0;
      pal       <= '0;
      idat      <= '0;
      out_valid <= 1'b0;
    end else begin
      width     <= width_next;
      height    <= height_next;
      hdr       <= hdr_next;
      pal       <= pal_next;
      idat      <= idat_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: hdl/png_chunk_stream_parser.sv
// With the result register free, a chunk's summary passes from its last CRC byte into the
//   command queue and then into the result register that drives the result ports.
// Throughput: one byte per cycle; full rises only while the result register is held and
//   the command queue has filled behind it.
// Reset: rst (synchronous) empties the queue and result register and returns the parser to
//   the signature check, fields zero; start_of_file does that last part for its own byte.
module png_chunk_stream_parser import pcsp_pkg::*; #(
  parameter int IDAT_COUNT_BITS = IDAT_COUNT_BITS_DEF,
  parameter int OPQ_DEPTH       = OPQ_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  // Front: walks signature, length, type, data and CRC fields a byte at a time and
  // turns the bytes that matter into commands for the back end.
  logic accept;
  logic front_push;
  op_t  front_op;

  // Queue between the two halves.
  logic q_full, q_empty;
  op_t  q_op;
  logic back_pop;

  // Accept a byte whenever the queue has room; bytes that need no command still count.
  assign full   = q_full;
  assign accept = push && !q_full;

  pcsp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .op_push (front_push),
    .op      (front_op)
  );

  pcsp_opq #(
    .DEPTH (OPQ_DEPTH)
  ) u_opq (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_op),
    .full  (q_full),
    .pop   (back_pop),
    .rdata (q_op),
    .empty (q_empty)
  );

  // Back: hold the IHDR, palette and IDAT state; drop a summary into the result
  // register on each finished chunk or bad signature.
  pcsp_back #(
    .IDAT_COUNT_BITS (IDAT_COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (!q_empty),
    .op       (q_op),
    .op_pop   (back_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

  // Nothing waits right after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queue or result not cleared by reset");

  // A signature failure carries no chunk type or length.
  a_bad_sig_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.status == ST_BAD_SIG)) |->
      ((result.chunk_type == '0) && (result.chunk_length == '0)))
    else $error("bad signature result has chunk fields set");

  // A short IHDR report must really be short.
  a_short_ihdr: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.status == ST_SHORT_IHDR)) |->
      ((result.chunk_length < 31'(IHDR_BYTES)) && (result.chunk_type == T_IHDR)))
    else $error("short IHDR status on a chunk that is not short");

  // The back end never pops a command that would emit while the result slot is held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop && !q_empty && ((q_op.kind == OP_END) || (q_op.kind == OP_BAD_SIG)))
      |-> !back_pop)
    else $error("result overwritten while held");

endmodule

FILE: bench/tb_png_chunk_stream_parser.sv
module tb_png_chunk_stream_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import pcsp_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int TOTAL_BYTES    = 1250;
  localparam int DIRECTED_BYTES = 25;
  localparam int STALL_LIMIT    = 2000;  // cycles in a row with no transfer on either side
  localparam int TAIL_CYCLES    = 10;    // lets the last summaries pass the queue and the result register
  localparam logic [15:0] IDAT_SATURATED = 16'hFFFF;

  // Chunk model: tracks the byte stream exactly as the parser should and
  // queues the per-chunk summaries it must produce, then checks them in order.
  class png_summary_board;
    phase_t      ph;
    logic [31:0] idx;
    logic [31:0] len_q;
    logic [31:0] type_q;
    logic [31:0] wid_q;
    logic [31:0] hgt_q;
    logic [39:0] hdr_q;
    logic [29:0] pal_q;
    logic [15:0] idat_q;
    bit          stopped;
    result_t     summaries[$];
    int          mismatches;

    function new();
      restart();
      mismatches = 0;
    endfunction

    function void restart();
      ph      = PH_SIG;
      idx     = '0;
      len_q   = '0;
      type_q  = '0;
      wid_q   = '0;
      hgt_q   = '0;
      hdr_q   = '0;
      pal_q   = '0;
      idat_q  = '0;
      stopped = 1'b0;
    endfunction

    function int pending();
      return summaries.size();
    endfunction

    function void queue_summary(logic [31:0] ctype, logic [30:0] clen, status_t st);
      result_t r;
      r.chunk_type       = ctype;
      r.chunk_length     = clen;
      r.image_width      = wid_q;
      r.image_height     = hgt_q;
      r.sample_depth     = hdr_q[39:32];
      r.color_kind       = hdr_q[31:24];
      r.compression_kind = hdr_q[23:16];
      r.filter_kind      = hdr_q[15:8];
      r.interlace_kind   = hdr_q[7:0];
      r.palette_entries  = pal_q;
      r.idat_count       = idat_q;
      r.status           = st;
      summaries.push_back(r);
    endfunction

    // Apply the per-type bookkeeping at the end of a chunk's CRC.
    function status_t close_chunk();
      status_t st;
      st = ST_OK;
      case (type_q)
        T_IHDR: if (len_q < IHDR_BYTES) st = ST_SHORT_IHDR;
        T_PLTE: begin
          if (len_q % 3 != 0) st = ST_BAD_PLTE;
          else pal_q = 30'(len_q / 3);
        end
        T_IDAT: if (idat_q != IDAT_SATURATED) idat_q++;
        T_IEND: st = ST_END;
        default: ;
      endcase
      if (st != ST_OK) stopped = 1'b1;
      ph  = PH_LEN;
      idx = '0;
      return st;
    endfunction

    function void note_byte(item_t it);
      logic [7:0] b;
      status_t    st;
      b = it.data_byte;
      if (it.start_of_file) restart();
      if (stopped) return;
      case (ph)
        PH_SIG: begin
          if (b != SIG_BYTES[idx[2:0]]) begin
            stopped = 1'b1;
            queue_summary('0, '0, ST_BAD_SIG);
          end else begin
            idx++;
            if (idx >= 8) begin
              ph  = PH_LEN;
              idx = '0;
            end
          end
        end
        PH_LEN: begin
          len_q = {len_q[23:0], b};
          idx++;
          if (idx >= 4) begin
            len_q[31] = 1'b0;
            ph        = PH_TYPE;
            idx       = '0;
          end
        end
        PH_TYPE: begin
          type_q = {type_q[23:0], b};
          idx++;
          if (idx >= 4) begin
            ph  = (len_q != 0) ? PH_DATA : PH_CRC;
            idx = '0;
          end
        end
        PH_DATA: begin
          if (type_q == T_IHDR && len_q >= IHDR_BYTES) begin
            if (idx < 4) wid_q = {wid_q[23:0], b};
            else if (idx < 8) hgt_q = {hgt_q[23:0], b};
            else if (idx < IHDR_BYTES) hdr_q = {hdr_q[31:0], b};
          end
          idx++;
          if (idx >= len_q) begin
            ph  = PH_CRC;
            idx = '0;
          end
        end
        PH_CRC: begin
          idx++;
          if (idx >= 4) begin
            st = close_chunk();
            queue_summary(type_q, len_q[30:0], st);
          end
        end
        default: begin
          ph  = PH_SIG;
          idx = '0;
        end
      endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %s: expected %h, got %h", name, want, got);
      end
    endfunction

    function void check_summary(result_t got);
      result_t want;
      if (summaries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected summary: type %h status %0d", got.chunk_type, got.status);
        return;
      end
      want = summaries.pop_front();
      check_field("chunk_type",       want.chunk_type,       got.chunk_type);
      check_field("chunk_length",     want.chunk_length,     got.chunk_length);
      check_field("image_width",      want.image_width,      got.image_width);
      check_field("image_height",     want.image_height,     got.image_height);
      check_field("sample_depth",     want.sample_depth,     got.sample_depth);
      check_field("color_kind",       want.color_kind,       got.color_kind);
      check_field("compression_kind", want.compression_kind, got.compression_kind);
      check_field("filter_kind",      want.filter_kind,      got.filter_kind);
      check_field("interlace_kind",   want.interlace_kind,   got.interlace_kind);
      check_field("palette_entries",  want.palette_entries,  got.palette_entries);
      check_field("idat_count",       want.idat_count,       got.idat_count);
      check_field("status",           want.status,           got.status);
    endfunction
  endclass

  logic    clk  = 1'b0;
  logic    rst  = 1'b1;
  logic    push = 1'b0;
  logic    pop  = 1'b0;
  item_t   item = '0;
  logic    full;
  logic    empty;
  result_t result;

  png_summary_board board;

  int send_idle_pct = 35;   // chance, drawn anew while idling, that the sender holds off before a byte
  int take_idle_pct = 68;   // chance the receiver holds off popping in a cycle
  int bytes_taken   = 0;    // bytes transferred into the parser so far
  int junk_bytes    = 0;    // trailing bytes sent only to be ignored
  int stall_run     = 0;

  png_chunk_stream_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver: decide on pop at the falling edge so it is stable at the rising edge.
  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= take_idle_pct);
  end

  // Monitor: sample both handshakes at the rising edge. Check the summary before
  // noting the byte so a summary never meets an expectation from the same edge.
  // Also run the watchdog here: any transfer clears the stall count.
  always @(posedge clk) begin
    if (!rst) begin
      stall_run++;
      if (pop && !empty) begin
        board.check_summary(result);
        stall_run = 0;
      end
      if (push && !full) begin
        board.note_byte(item);
        bytes_taken++;
        stall_run = 0;
      end
      if (stall_run >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Drive one byte and hold it until the parser takes it; return at a falling edge.
  task automatic send_byte(input logic [7:0] data, input logic sof);
    int target;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    target = bytes_taken + 1;
    push <= 1'b1;
    item <= '{data_byte: data, start_of_file: sof};
    do @(negedge clk); while (bytes_taken < target);
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8], 1'b0);
  endtask

  // Length word, type word, data bytes, then four CRC bytes the parser never checks.
  task automatic send_chunk(input logic [31:0] ctype, input logic [31:0] len_w);
    send_word(len_w);
    send_word(ctype);
    for (int i = 0; i < int'(len_w[30:0]); i++) send_byte(8'($urandom), 1'b0);
    send_word($urandom);
  endtask

  // Set the top length bit now and then; the parser must drop it.
  function automatic logic [31:0] chunk_len(input int n);
    return {($urandom_range(9) == 0), 31'(n)};
  endfunction

  // Bytes after the parser has stopped; none of them may produce a summary.
  task automatic send_junk();
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
    junk_bytes += n;
  endtask

  task automatic send_ihdr();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 8) n = $urandom_range(0, IHDR_BYTES - 1);      // too short: halts the file
    else if (r < 28) n = $urandom_range(IHDR_BYTES + 1, 18);
    else n = IHDR_BYTES;
    send_chunk(T_IHDR, chunk_len(n));
  endtask

  // One file: mostly well formed with random content, some broken or cut short,
  // a few plain noise.
  task automatic send_file();
    int shape;
    int bad_at;
    int chunks;
    int r;
    int n;
    shape = $urandom_range(99);
    if (shape < 6) begin
      n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), $urandom_range(7) == 0);
      return;
    end

    // Signature, now and then with one byte corrupted.
    bad_at = ($urandom_range(99) < 8) ? $urandom_range(7) : -1;
    for (int i = 0; i < 8; i++)
      send_byte((i == bad_at) ? (SIG_BYTES[i] ^ 8'($urandom_range(1, 255))) : SIG_BYTES[i],
                (i == 0) && ($urandom_range(19) != 0));
    if (board.stopped) begin
      send_junk();
      return;
    end

    if ($urandom_range(99) < 85) send_ihdr();
    if (board.stopped) begin
      send_junk();
      return;
    end

    chunks = $urandom_range(0, 6);
    for (int c = 0; c < chunks; c++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        send_chunk(T_IDAT, chunk_len($urandom_range(0, 24)));
      end else if (r < 60) begin
        n = 3 * $urandom_range(0, 10);
        if ($urandom_range(99) < 15) n += $urandom_range(1, 2);   // bad palette length
        send_chunk(T_PLTE, chunk_len(n));
      end else if (r < 85) begin
        send_chunk($urandom, chunk_len($urandom_range(0, 12)));
      end else if (r < 92) begin
        send_ihdr();                                            // repeated header
      end else begin
        send_chunk($urandom, chunk_len($urandom_range(100, 400)));
      end
      if (board.stopped) begin
        send_junk();
        return;
      end
    end

    r = $urandom_range(99);
    if (r < 85) begin
      send_chunk(T_IEND, chunk_len(($urandom_range(9) == 0) ? $urandom_range(1, 8) : 0));
      send_junk();
    end else if (r >= 93) begin
      // Cut off inside a chunk; the next start flag must recover.
      send_word(chunk_len($urandom_range(4, 20)));
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
    end
  endtask

  // Hold off the sender until every queued summary has been popped.
  task automatic drain_summaries();
    push <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
  endtask

  initial begin
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Signature with no start flag at all, then an empty IEND straight after it.
    for (int i = 0; i < 8; i++) send_byte(SIG_BYTES[i], 1'b0);
    send_word(32'd0);
    send_word(T_IEND);
    send_word(32'hFFFF_FFFF);
    // Bad signature on the first byte, two ignored bytes, bad on the second byte.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h89, 1'b0);
    send_byte(8'h89, 1'b1);
    send_byte(8'hAF, 1'b0);

    // Three idling regimes; drain between them so the sender pauses fully.
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 35 : (p == 1) ? 68 : 0;
      take_idle_pct = (p == 0) ? 68 : (p == 1) ? 35 : 0;
      while (bytes_taken - junk_bytes
             < DIRECTED_BYTES + (p + 1) * (TOTAL_BYTES - DIRECTED_BYTES) / 3)
        send_file();
      drain_summaries();
    end

    // Let any stray summary surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
